// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define B2D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is checked at every edge, reset included.
`define B2D_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/b2d_pkg.sv =====
// Shared constants and elaboration helpers for the decimal ASCII printer.
package b2d_pkg;

    localparam int MAG_W          = 32;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Decimal digits needed for the largest value of the given bit width.
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

// ===== rtl/b2d_dabble.sv =====
// Shift-add-3 converter that turns a binary value into packed BCD, one bit per cycle.
module b2d_dabble #(
    parameter int VALUE_BITS = b2d_pkg::DEF_VALUE_BITS,
    parameter int NUM_DIGITS = b2d_pkg::num_digits(b2d_pkg::DEF_VALUE_BITS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [VALUE_BITS-1:0]                  i_value,
    output logic                                   o_done,
    output logic [NUM_DIGITS*b2d_pkg::DIGIT_W-1:0] o_bcd
);
    import b2d_pkg::*;

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [BCD_W-1:0]      n_bcd;
    logic [VALUE_BITS-1:0] n_bin;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                w_adj[d*DIGIT_W +: DIGIT_W] = 4'(r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3);
            end else begin
                w_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
        n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_value;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bin <= n_bin;
                r_bcd <= n_bcd;
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/b2d_emit.sv =====
// Character emitter that drops leading zeros and sends sign and digits one per transfer.
module b2d_emit #(
    parameter int NUM_DIGITS = b2d_pkg::num_digits(b2d_pkg::DEF_VALUE_BITS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_negative,
    input  logic                                   i_done,
    input  logic [NUM_DIGITS*b2d_pkg::DIGIT_W-1:0] i_bcd,
    output logic                                   o_idle,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [b2d_pkg::CHAR_W-1:0]             o_character,
    output logic                                   o_last
);
    import b2d_pkg::*;

    localparam int BCD_W  = NUM_DIGITS * DIGIT_W;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic                 r_neg;
    logic [BCD_W-1:0]     r_bcd;
    logic [LEFT_W-1:0]    r_left;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic [DIGIT_W-1:0]   w_top;
    logic                 w_one_left;

    assign w_top      = r_bcd[BCD_W-1 -: DIGIT_W];
    assign w_one_left = (r_left == LEFT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            if (r_valid && i_ready && r_state != S_EMIT) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_negative;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (i_done) begin
                        r_bcd   <= i_bcd;
                        r_left  <= LEFT_W'(NUM_DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_top == '0 && !w_one_left) begin
                        r_bcd  <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        r_left <= LEFT_W'(r_left - 1'b1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        if (r_neg) begin
                            r_char <= ASCII_MINUS;
                            r_last <= 1'b0;
                            r_neg  <= 1'b0;
                        end else begin
                            r_char <= CHAR_W'(ASCII_ZERO + CHAR_W'(w_top));
                            r_last <= w_one_left;
                            r_bcd  <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                            r_left <= LEFT_W'(r_left - 1'b1);
                            if (w_one_left) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII printer.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_ready   i_magnitude, i_negative
//   output   out        o_valid / i_ready   o_character, o_last
//
// After the accepting edge the converter runs one shift-add-3 step per input bit and then
// hands its BCD result to the emitter. Leading zeros are then dropped at one per cycle,
// up to NUM_DIGITS-1 of them, before the emit state is entered. Each character takes one
// output transfer. A stalled output holds the emitter in place, and the next value is taken
// once the last character sits in the output register.
// Reset is synchronous and active low and empties both the converter and the output.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2d_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [b2d_pkg::MAG_W-1:0]     i_magnitude,
    input  logic                          i_negative,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [b2d_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last
);
    import b2d_pkg::*;

    localparam int NUM_DIGITS = num_digits(VALUE_BITS);

    logic                          w_start;
    logic                          w_idle;
    logic                          w_done;
    logic [VALUE_BITS-1:0]         w_value;
    logic [NUM_DIGITS*DIGIT_W-1:0] w_bcd;

    assign w_value = VALUE_BITS'(i_magnitude);
    assign o_ready = w_idle;
    assign w_start = i_valid && w_idle;

    b2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (w_value),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    b2d_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_negative  (i_negative),
        .i_done      (w_done),
        .i_bcd       (w_bcd),
        .o_idle      (w_idle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/b2d_checker.sv =====
// Port-level checker for the decimal ASCII printer, bound to the top level.
`include "assert_macros.svh"

module b2d_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [b2d_pkg::CHAR_W-1:0] o_character,
    input logic                       o_last
);
    import b2d_pkg::*;

    logic w_char_ok;

    assign w_char_ok = (o_character == ASCII_MINUS) ||
                       (o_character >= ASCII_ZERO &&
                        o_character <= CHAR_W'(ASCII_ZERO + 8'd9));

    `B2D_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)
    `B2D_ASSERT(a_char_legal, i_clk, i_rst_n, o_valid |-> w_char_ok)
    `B2D_ASSERT(a_minus_not_last, i_clk, i_rst_n, (o_valid && o_character == ASCII_MINUS) |-> !o_last)
    `B2D_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_character) && $stable(o_last)))
    `B2D_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
